// ----- hdl/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, constants and helpers for the point rotation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int ADDR_WIDTH   = 5;
  localparam int DATA_WIDTH   = 32;
  localparam int NUM_REGS     = 6;
  localparam int NUM_AXES     = 3;

  // rotated coordinates grow by at most one bit per axis
  localparam int INT_WIDTH    = COORD_WIDTH + 4;
  localparam int TRIG_WIDTH   = 16;
  localparam int TRIG_FRAC    = 14;
  localparam int PROD_WIDTH   = INT_WIDTH + TRIG_WIDTH;
  localparam int SUM_WIDTH    = PROD_WIDTH + 1;

  localparam int TURN_WIDTH   = 24;
  localparam int QUARTER_BITS = 22;
  localparam int COEF_FRAC    = 30;
  localparam int FIN_SHIFT    = QUARTER_BITS + COEF_FRAC - TRIG_FRAC;
  localparam int U_WIDTH      = QUARTER_BITS + 1;
  localparam int POLY_WIDTH   = 33;
  localparam int DIGIT_WIDTH  = 8;
  localparam int NUM_DIGITS   = 3;
  localparam int DIGIT_IDX_W  = $clog2(NUM_DIGITS);
  localparam int MULB_WIDTH   = DIGIT_WIDTH * NUM_DIGITS;
  localparam int PP_WIDTH     = POLY_WIDTH + DIGIT_WIDTH + 1;
  localparam int ACC_WIDTH    = POLY_WIDTH + MULB_WIDTH + 1;

  localparam int PIPE_LATENCY = 8;

  localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(16384);
  localparam logic signed [SUM_WIDTH-1:0]  ROT_BIAS = SUM_WIDTH'(1) << (TRIG_FRAC - 1);
  localparam logic signed [ACC_WIDTH-1:0]  FIN_BIAS = ACC_WIDTH'(1) << (FIN_SHIFT - 1);

  localparam logic signed [POLY_WIDTH-1:0] K1 = POLY_WIDTH'(1686629713);
  localparam logic signed [POLY_WIDTH-1:0] K3 = POLY_WIDTH'(-693598668);
  localparam logic signed [POLY_WIDTH-1:0] K5 = POLY_WIDTH'(85569298);
  localparam logic signed [POLY_WIDTH-1:0] K7 = POLY_WIDTH'(-5026990);
  localparam logic signed [POLY_WIDTH-1:0] K9 = POLY_WIDTH'(172275);

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_ANGLE_X,
    REG_ANGLE_Y,
    REG_ANGLE_Z
  } prc_reg_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } prc_axis_t;

  typedef enum logic [2:0] {
    STEP_SQUARE,
    STEP_K7,
    STEP_K5,
    STEP_K3,
    STEP_K1,
    STEP_FINAL
  } prc_step_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_POST
  } prc_seq_state_t;

  typedef logic signed [INT_WIDTH-1:0] prc_coord_t;

  typedef struct packed {
    logic signed [TRIG_WIDTH-1:0] sin_v;
    logic signed [TRIG_WIDTH-1:0] cos_v;
  } prc_trig_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] center_x;
    logic [COORD_WIDTH-1:0] center_y;
    logic [COORD_WIDTH-1:0] center_z;
    logic [ANGLE_WIDTH-1:0] angle_x;
    logic [ANGLE_WIDTH-1:0] angle_y;
    logic [ANGLE_WIDTH-1:0] angle_z;
  } prc_cfg_t;

  function automatic logic signed [POLY_WIDTH-1:0] horner_coef(prc_step_t step);
    logic signed [POLY_WIDTH-1:0] k;
    case (step)
      STEP_K7: k = K7;
      STEP_K5: k = K5;
      STEP_K3: k = K3;
      default: k = K1;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/prc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// prc_cfg_regs
// APB register file: rotation center and the three rotation angles.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [prc_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [prc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic      [prc_pkg::DATA_WIDTH-1:0] prdata,
  output prc_pkg::prc_cfg_t                   cfg,
  output logic      [prc_pkg::NUM_AXES-1:0]   angle_wr
);
  import prc_pkg::*;

  prc_cfg_t cfg_r;
  prc_reg_t idx;
  logic     wr_en;

  assign idx   = prc_reg_t'(paddr[ADDR_WIDTH-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CENTER_X: cfg_r.center_x <= pwdata[COORD_WIDTH-1:0];
        REG_CENTER_Y: cfg_r.center_y <= pwdata[COORD_WIDTH-1:0];
        REG_CENTER_Z: cfg_r.center_z <= pwdata[COORD_WIDTH-1:0];
        REG_ANGLE_X:  cfg_r.angle_x  <= pwdata[ANGLE_WIDTH-1:0];
        REG_ANGLE_Y:  cfg_r.angle_y  <= pwdata[ANGLE_WIDTH-1:0];
        REG_ANGLE_Z:  cfg_r.angle_z  <= pwdata[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    angle_wr = '0;
    if (wr_en && rst_n) begin
      case (idx)
        REG_ANGLE_X: angle_wr[AXIS_X] = 1'b1;
        REG_ANGLE_Y: angle_wr[AXIS_Y] = 1'b1;
        REG_ANGLE_Z: angle_wr[AXIS_Z] = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X: prdata = DATA_WIDTH'(cfg_r.center_x);
      REG_CENTER_Y: prdata = DATA_WIDTH'(cfg_r.center_y);
      REG_CENTER_Z: prdata = DATA_WIDTH'(cfg_r.center_z);
      REG_ANGLE_X:  prdata = DATA_WIDTH'(cfg_r.angle_x);
      REG_ANGLE_Y:  prdata = DATA_WIDTH'(cfg_r.angle_y);
      REG_ANGLE_Z:  prdata = DATA_WIDTH'(cfg_r.angle_z);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/prc_trig_seq.sv -----
// ----------------------------------------------------------------------------
// prc_trig_seq
// Sine/cosine sequencer: evaluates the quarter-wave polynomial for each
// rewritten angle on one shared 33x8 digit multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_trig_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire prc_pkg::prc_cfg_t            cfg,
  input  wire logic [prc_pkg::NUM_AXES-1:0] angle_wr,
  output prc_pkg::prc_trig_t                trig_x,
  output prc_pkg::prc_trig_t                trig_y,
  output prc_pkg::prc_trig_t                trig_z,
  output logic                              seq_busy
);
  import prc_pkg::*;

  prc_seq_state_t                 state_r, state_nxt;
  logic [NUM_AXES-1:0]            dirty_r, dirty_nxt;
  prc_axis_t                      axis_r, axis_nxt;
  logic [1:0]                     quad_r, quad_nxt;
  logic [QUARTER_BITS-1:0]        rem_r, rem_nxt;
  logic [U_WIDTH-1:0]             u_r, u_nxt;
  logic [U_WIDTH-1:0]             z_r, z_nxt;
  logic signed [POLY_WIDTH-1:0]   p_r, p_nxt;
  logic signed [ACC_WIDTH-1:0]    acc_r, acc_nxt;
  prc_step_t                      step_r, step_nxt;
  logic [DIGIT_IDX_W-1:0]         digit_r, digit_nxt;
  logic                           phase_r, phase_nxt;
  logic signed [TRIG_WIDTH-1:0]   sval_r, sval_nxt;
  prc_trig_t                      trig_r [NUM_AXES];
  prc_trig_t                      trig_nxt [NUM_AXES];

  prc_axis_t                      pick;
  logic [ANGLE_WIDTH-1:0]         pick_angle;
  logic [TURN_WIDTH-1:0]          turn;
  logic signed [POLY_WIDTH-1:0]   mul_a;
  logic [MULB_WIDTH-1:0]          mul_b;
  logic [DIGIT_WIDTH-1:0]         digit;
  logic signed [PP_WIDTH-1:0]     pp;
  logic signed [ACC_WIDTH-1:0]    pp_sh;
  logic signed [ACC_WIDTH-1:0]    acc_q;
  logic signed [POLY_WIDTH-1:0]   horner_val;
  logic signed [ACC_WIDTH-1:0]    fin;
  logic signed [TRIG_WIDTH-1:0]   fin_clamp;

  assign trig_x   = trig_r[AXIS_X];
  assign trig_y   = trig_r[AXIS_Y];
  assign trig_z   = trig_r[AXIS_Z];
  assign seq_busy = (state_r != SEQ_IDLE) || (dirty_r != '0);

  always_comb begin
    if (dirty_r[AXIS_X]) begin
      pick       = AXIS_X;
      pick_angle = cfg.angle_x;
    end else if (dirty_r[AXIS_Y]) begin
      pick       = AXIS_Y;
      pick_angle = cfg.angle_y;
    end else begin
      pick       = AXIS_Z;
      pick_angle = cfg.angle_z;
    end
    turn = TURN_WIDTH'(pick_angle) << (TURN_WIDTH - ANGLE_WIDTH);
  end

  // one 8-bit digit of the unsigned operand per cycle while in SEQ_MUL
  always_comb begin
    case (step_r)
      STEP_SQUARE: begin
        mul_a = $signed(POLY_WIDTH'(u_r));
        mul_b = MULB_WIDTH'(u_r);
      end
      STEP_FINAL: begin
        mul_a = p_r;
        mul_b = MULB_WIDTH'(u_r);
      end
      default: begin
        mul_a = p_r;
        mul_b = MULB_WIDTH'(z_r);
      end
    endcase
    digit = mul_b[digit_r*DIGIT_WIDTH +: DIGIT_WIDTH];
    pp    = mul_a * $signed({1'b0, digit});
    pp_sh = ACC_WIDTH'(pp) <<< (DIGIT_WIDTH * digit_r);
  end

  always_comb begin
    acc_q      = acc_r >>> QUARTER_BITS;
    horner_val = horner_coef(step_r) + $signed(acc_q[POLY_WIDTH-1:0]);
    fin        = (acc_r + FIN_BIAS) >>> FIN_SHIFT;
    if (fin < 0) begin
      fin_clamp = '0;
    end else if (fin > ACC_WIDTH'(TRIG_ONE)) begin
      fin_clamp = TRIG_ONE;
    end else begin
      fin_clamp = fin[TRIG_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    dirty_nxt = dirty_r;
    axis_nxt  = axis_r;
    quad_nxt  = quad_r;
    rem_nxt   = rem_r;
    u_nxt     = u_r;
    z_nxt     = z_r;
    p_nxt     = p_r;
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    digit_nxt = digit_r;
    phase_nxt = phase_r;
    sval_nxt  = sval_r;
    trig_nxt  = trig_r;
    case (state_r)
      SEQ_IDLE: begin
        if (dirty_r != '0) begin
          axis_nxt        = pick;
          dirty_nxt[pick] = 1'b0;
          quad_nxt        = turn[TURN_WIDTH-1 -: 2];
          rem_nxt         = turn[QUARTER_BITS-1:0];
          u_nxt           = U_WIDTH'(turn[QUARTER_BITS-1:0]);
          step_nxt        = STEP_SQUARE;
          digit_nxt       = '0;
          acc_nxt         = '0;
          phase_nxt       = 1'b0;
          state_nxt       = SEQ_MUL;
        end
      end
      SEQ_MUL: begin
        acc_nxt = acc_r + pp_sh;
        if (digit_r == DIGIT_IDX_W'(NUM_DIGITS - 1)) begin
          state_nxt = SEQ_POST;
        end else begin
          digit_nxt = digit_r + 1'b1;
        end
      end
      SEQ_POST: begin
        digit_nxt = '0;
        acc_nxt   = '0;
        state_nxt = SEQ_MUL;
        case (step_r)
          STEP_SQUARE: begin
            z_nxt    = acc_r[QUARTER_BITS +: U_WIDTH];
            p_nxt    = K9;
            step_nxt = STEP_K7;
          end
          STEP_K7: begin
            p_nxt    = horner_val;
            step_nxt = STEP_K5;
          end
          STEP_K5: begin
            p_nxt    = horner_val;
            step_nxt = STEP_K3;
          end
          STEP_K3: begin
            p_nxt    = horner_val;
            step_nxt = STEP_K1;
          end
          STEP_K1: begin
            p_nxt    = horner_val;
            step_nxt = STEP_FINAL;
          end
          STEP_FINAL: begin
            if (!phase_r) begin
              sval_nxt  = fin_clamp;
              phase_nxt = 1'b1;
              u_nxt     = (U_WIDTH'(1) << QUARTER_BITS) - U_WIDTH'(rem_r);
              step_nxt  = STEP_SQUARE;
            end else begin
              case (quad_r)
                2'd0: begin
                  trig_nxt[axis_r].sin_v = sval_r;
                  trig_nxt[axis_r].cos_v = fin_clamp;
                end
                2'd1: begin
                  trig_nxt[axis_r].sin_v = fin_clamp;
                  trig_nxt[axis_r].cos_v = -sval_r;
                end
                2'd2: begin
                  trig_nxt[axis_r].sin_v = -sval_r;
                  trig_nxt[axis_r].cos_v = -fin_clamp;
                end
                default: begin
                  trig_nxt[axis_r].sin_v = -fin_clamp;
                  trig_nxt[axis_r].cos_v = sval_r;
                end
              endcase
              state_nxt = SEQ_IDLE;
            end
          end
          default: state_nxt = SEQ_IDLE;
        endcase
      end
      default: state_nxt = SEQ_IDLE;
    endcase
    dirty_nxt = dirty_nxt | angle_wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      dirty_r <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        trig_r[i].sin_v <= '0;
        trig_r[i].cos_v <= TRIG_ONE;
      end
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
      trig_r  <= trig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r  <= axis_nxt;
    quad_r  <= quad_nxt;
    rem_r   <= rem_nxt;
    u_r     <= u_nxt;
    z_r     <= z_nxt;
    p_r     <= p_nxt;
    acc_r   <= acc_nxt;
    step_r  <= step_nxt;
    digit_r <= digit_nxt;
    phase_r <= phase_nxt;
    sval_r  <= sval_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/prc_rot_stage.sv -----
// ----------------------------------------------------------------------------
// prc_rot_stage
// Two-stage planar rotation of one coordinate pair; the third coordinate
// rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_rot_stage (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         vld_in,
  input  wire prc_pkg::prc_coord_t a_in,
  input  wire prc_pkg::prc_coord_t b_in,
  input  wire prc_pkg::prc_coord_t p_in,
  input  wire prc_pkg::prc_trig_t  trig,
  output logic              vld_out,
  output prc_pkg::prc_coord_t a_out,
  output prc_pkg::prc_coord_t b_out,
  output prc_pkg::prc_coord_t p_out
);
  import prc_pkg::*;

  logic                         vld1_r;
  logic signed [PROD_WIDTH-1:0] ca_r, sb_r, sa_r, cb_r;
  logic signed [PROD_WIDTH-1:0] ca_nxt, sb_nxt, sa_nxt, cb_nxt;
  prc_coord_t                   p1_r;

  logic                         vld2_r;
  prc_coord_t                   a2_r, b2_r, p2_r;
  logic signed [SUM_WIDTH-1:0]  sum_a, sum_b;

  always_comb begin
    ca_nxt = trig.cos_v * a_in;
    sb_nxt = trig.sin_v * b_in;
    sa_nxt = trig.sin_v * a_in;
    cb_nxt = trig.cos_v * b_in;
  end

  always_comb begin
    sum_a = SUM_WIDTH'(ca_r) - SUM_WIDTH'(sb_r) + ROT_BIAS;
    sum_b = SUM_WIDTH'(sa_r) + SUM_WIDTH'(cb_r) + ROT_BIAS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    ca_r <= ca_nxt;
    sb_r <= sb_nxt;
    sa_r <= sa_nxt;
    cb_r <= cb_nxt;
    p1_r <= p_in;
    a2_r <= sum_a[TRIG_FRAC +: INT_WIDTH];
    b2_r <= sum_b[TRIG_FRAC +: INT_WIDTH];
    p2_r <= p1_r;
  end

  assign vld_out = vld2_r;
  assign a_out   = a2_r;
  assign b_out   = b2_r;
  assign p_out   = p2_r;

endmodule

`default_nettype wire

// ----- hdl/point_rotate_xyz_about_center_unit.sv -----
// ----------------------------------------------------------------------------
// point_rotate_xyz_about_center_unit
// Rotates Q8.8 points about a center: x axis, then y, then z.
//
// Input: an item is taken at a rising edge with start high and busy low.
// Output: out_valid is high for one cycle with out_rotated_x/y/z; the
//   receiver cannot hold results off and the pipeline never stalls.
// Throughput: one point per cycle while busy is low, fully pipelined (8 register
//   stages: center subtract, two per axis rotation, center add and saturate).
// Configuration: APB port, center_x/y/z and angle_x/y/z at 4*i.
//   An angle write starts the sine/cosine sequencer for that axis; busy stays
//   high after each angle write beat while a shared 33x8 multiplier steps
//   through the polynomial. busy is also high during a write access.
// Reset: synchronous, active low. Clears the registers (angles 0, center 0),
//   loads the angle-0 sine/cosine, drops all valid bits; busy is high during
//   reset.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotate_xyz_about_center_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [prc_pkg::COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [prc_pkg::COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [prc_pkg::COORD_WIDTH-1:0] in_point_z,
  output logic                                   out_valid,
  output logic signed [prc_pkg::COORD_WIDTH-1:0] out_rotated_x,
  output logic signed [prc_pkg::COORD_WIDTH-1:0] out_rotated_y,
  output logic signed [prc_pkg::COORD_WIDTH-1:0] out_rotated_z,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [prc_pkg::ADDR_WIDTH-1:0]    paddr,
  input  wire logic [prc_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic      [prc_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                                   pready
);
  import prc_pkg::*;

  localparam logic signed [INT_WIDTH:0] SAT_HI = {{(INT_WIDTH-COORD_WIDTH+2){1'b0}},
                                                  {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [INT_WIDTH:0] SAT_LO = {{(INT_WIDTH-COORD_WIDTH+2){1'b1}},
                                                  {(COORD_WIDTH-1){1'b0}}};

  prc_cfg_t             cfg;
  logic [NUM_AXES-1:0]  angle_wr;
  prc_trig_t            trig_x, trig_y, trig_z;
  logic                 seq_busy;
  logic                 accept;

  logic                 vld0_r;
  prc_coord_t           x0_r, y0_r, z0_r;

  logic                 vld1, vld2, vld3;
  prc_coord_t           x1, y1, z1, x2, y2, z2, x3, y3, z3;

  logic                 out_valid_r;
  logic signed [COORD_WIDTH-1:0] rx_r, ry_r, rz_r;

  function automatic logic signed [COORD_WIDTH-1:0] sat_add(prc_coord_t v,
                                                            logic [COORD_WIDTH-1:0] c);
    logic signed [INT_WIDTH:0] s;
    logic signed [COORD_WIDTH-1:0] r;
    s = (INT_WIDTH+1)'(v) + (INT_WIDTH+1)'($signed(c));
    if (s > SAT_HI) begin
      r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (s < SAT_LO) begin
      r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      r = s[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign busy   = !rst_n || seq_busy || (psel && penable && pwrite);
  assign accept = start && !busy;

  prc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .cfg      (cfg),
    .angle_wr (angle_wr)
  );

  prc_trig_seq u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .angle_wr (angle_wr),
    .trig_x   (trig_x),
    .trig_y   (trig_y),
    .trig_z   (trig_z),
    .seq_busy (seq_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= INT_WIDTH'(in_point_x) - INT_WIDTH'($signed(cfg.center_x));
    y0_r <= INT_WIDTH'(in_point_y) - INT_WIDTH'($signed(cfg.center_y));
    z0_r <= INT_WIDTH'(in_point_z) - INT_WIDTH'($signed(cfg.center_z));
  end

  // about x: pair (y, z)
  prc_rot_stage u_rot_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (vld0_r),
    .a_in    (y0_r),
    .b_in    (z0_r),
    .p_in    (x0_r),
    .trig    (trig_x),
    .vld_out (vld1),
    .a_out   (y1),
    .b_out   (z1),
    .p_out   (x1)
  );

  // about y: pair (z, x)
  prc_rot_stage u_rot_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (vld1),
    .a_in    (z1),
    .b_in    (x1),
    .p_in    (y1),
    .trig    (trig_y),
    .vld_out (vld2),
    .a_out   (z2),
    .b_out   (x2),
    .p_out   (y2)
  );

  // about z: pair (x, y)
  prc_rot_stage u_rot_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (vld2),
    .a_in    (x2),
    .b_in    (y2),
    .p_in    (z2),
    .trig    (trig_z),
    .vld_out (vld3),
    .a_out   (x3),
    .b_out   (y3),
    .p_out   (z3)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    rx_r <= sat_add(x3, cfg.center_x);
    ry_r <= sat_add(y3, cfg.center_y);
    rz_r <= sat_add(z3, cfg.center_z);
  end

  assign out_valid     = out_valid_r;
  assign out_rotated_x = rx_r;
  assign out_rotated_y = ry_r;
  assign out_rotated_z = rz_r;

endmodule

`default_nettype wire

// ----- hdl/prc_checker.sv -----
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks for the point rotation unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           out_valid,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [prc_pkg::ADDR_WIDTH-1:0] paddr,
  input wire logic [prc_pkg::DATA_WIDTH-1:0] pwdata,
  input wire logic [prc_pkg::DATA_WIDTH-1:0] prdata
);
  import prc_pkg::*;

  logic in_beat;
  logic wr_beat;

  assign in_beat = start && !busy;
  assign wr_beat = psel && penable && pwrite;

  // every accepted point comes out after the fixed latency
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |-> ##PIPE_LATENCY out_valid)
    else $error("accepted point produced no result");

  // no result without a matching accepted point
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_beat, PIPE_LATENCY))
    else $error("result without accepted point");

  // angle writes hold off new points: busy must be high right after an angle write beat
  a_angle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_beat && (paddr[ADDR_WIDTH-1:2] == REG_ANGLE_X ||
                 paddr[ADDR_WIDTH-1:2] == REG_ANGLE_Y ||
                 paddr[ADDR_WIDTH-1:2] == REG_ANGLE_Z)) |=> busy)
    else $error("not busy after angle write");

  // center registers read back what was written
  a_center_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_beat && (paddr[ADDR_WIDTH-1:2] == REG_CENTER_X ||
                 paddr[ADDR_WIDTH-1:2] == REG_CENTER_Y ||
                 paddr[ADDR_WIDTH-1:2] == REG_CENTER_Z)) |=>
    (paddr != $past(paddr) ||
     prdata == DATA_WIDTH'($past(pwdata[COORD_WIDTH-1:0]))))
    else $error("center register readback mismatch");

endmodule

bind point_rotate_xyz_about_center_unit prc_checker u_prc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

`default_nettype wire
